@@ design/assert_macros.svh @@
// Assertion macros used by the slot allocator module.
// Depends on nothing; each user supplies clk and arst_n in its scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ design/gsa_pkg.sv @@
// Package of the generational slot allocator: sizes, operation and status codes,
// and the result record. Depends on nothing.
package gsa_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int GEN_W      = 16;
	localparam int FLAG_W     = 8;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PORT_IDX_W = 8;
	localparam int CHUNK      = 8;
	localparam int NUM_CHUNKS = (SLOT_COUNT + CHUNK - 1) / CHUNK;
	localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int PE_W       = $clog2(CHUNK);

	localparam logic [1:0] MODE_CREATE  = 2'd0;
	localparam logic [1:0] MODE_LOOKUP  = 2'd1;
	localparam logic [1:0] MODE_DESTROY = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_GEN      = 3'd3;
	localparam logic [2:0] ST_INACTIVE = 3'd4;

	typedef struct packed {
		logic              active;
		logic [FLAG_W-1:0] flags;
		logic [GEN_W-1:0]  gen;
		logic [PORT_IDX_W-1:0] idx;
		logic [2:0]        status;
	} result_t;

endpackage

@@ design/generational_slot_allocator.sv @@
// Generational slot allocator: a pool of SLOT_COUNT slots with active marks,
// flags and generation counts served one request at a time.
// Depends on gsa_pkg and assert_macros.svh.
//
// The block takes one request beat, works on it, and presents one result beat.
// For lookup and destroy requests the accepting cycle addresses the slot memory,
// the read state reads and updates the slot, and the done state loads the output
// register once it is empty or being taken. An index out of range skips the slot
// access. Create first runs the free-slot scan, which tests eight active marks
// per cycle, the lowest free slot being found soonest; a full pool gives its
// result once every chunk has been scanned. A new request is accepted once the
// previous result sits in the output register, even if it has not yet been taken.
// Slots never written read as zero, so no clearing pass follows reset.
`include "assert_macros.svh"

module generational_slot_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // slot_index, handle_generation, flags_in
	input  logic [1:0]  s_tuser,  // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // status, result_index, result_generation,
	                              // result_flags, result_active, zero pad
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam int WORD_W = gsa_pkg::GEN_W + gsa_pkg::FLAG_W;

	logic [1:0]                      state_q;
	logic [1:0]                      mode_q;
	logic [gsa_pkg::PORT_IDX_W-1:0]  in_idx;
	logic [gsa_pkg::GEN_W-1:0]       in_gen;
	logic [gsa_pkg::FLAG_W-1:0]      in_flags;
	logic [gsa_pkg::GEN_W-1:0]       hgen_q;
	logic [gsa_pkg::FLAG_W-1:0]      flags_q;
	logic [gsa_pkg::IDX_W-1:0]       slot_q;
	logic [gsa_pkg::CHUNK_W-1:0]     chunk_q;
	logic [gsa_pkg::SLOT_COUNT-1:0]  active_q;
	logic [gsa_pkg::SLOT_COUNT-1:0]  written_q;
	logic [WORD_W-1:0]               slot_mem_q [gsa_pkg::SLOT_COUNT];
	logic [WORD_W-1:0]               rd_word_q;
	logic                            rd_valid_q;
	logic [gsa_pkg::IDX_W-1:0]       rd_addr;
	logic                            wr_en;
	logic [WORD_W-1:0]               wr_word;
	logic [gsa_pkg::NUM_CHUNKS*gsa_pkg::CHUNK-1:0] padded_active;
	logic [gsa_pkg::CHUNK-1:0]       free_bits;
	logic                            free_hit;
	logic [gsa_pkg::PE_W-1:0]        free_pe;
	logic [gsa_pkg::IDX_W-1:0]       found_idx;
	logic [gsa_pkg::GEN_W-1:0]       rd_gen;
	logic [gsa_pkg::FLAG_W-1:0]      rd_flags;
	logic [gsa_pkg::GEN_W-1:0]       next_gen;
	logic                            accept;
	logic                            in_range;
	logic                            out_load;
	gsa_pkg::result_t                res_q;
	gsa_pkg::result_t                res_rd;
	logic                            m_tvalid_q;
	logic [39:0]                     m_tdata_q;

	assign in_idx   = s_tdata[7:0];
	assign in_gen   = s_tdata[23:8];
	assign in_flags = s_tdata[31:24];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_range = {1'b0, in_idx} < 9'(gsa_pkg::SLOT_COUNT);
	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		padded_active = '1;
		padded_active[gsa_pkg::SLOT_COUNT-1:0] = active_q;
		free_bits = ~padded_active[chunk_q*gsa_pkg::CHUNK +: gsa_pkg::CHUNK];
		free_hit  = |free_bits;
		free_pe   = '0;
		for (int i = gsa_pkg::CHUNK - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				free_pe = gsa_pkg::PE_W'(i);
			end
		end
	end

	assign found_idx = gsa_pkg::IDX_W'({chunk_q, free_pe});
	assign rd_addr   = (state_q == S_SCAN) ? found_idx : in_idx[gsa_pkg::IDX_W-1:0];

	always_ff @(posedge clk) begin
		rd_word_q  <= slot_mem_q[rd_addr];
		rd_valid_q <= written_q[rd_addr];
		if (wr_en) begin
			slot_mem_q[slot_q] <= wr_word;
		end
	end

	assign rd_gen   = rd_valid_q ? rd_word_q[WORD_W-1:gsa_pkg::FLAG_W] : '0;
	assign rd_flags = rd_valid_q ? rd_word_q[gsa_pkg::FLAG_W-1:0] : '0;
	assign next_gen = hgen_q + gsa_pkg::GEN_W'(1);

	always_comb begin
		wr_en   = 1'b0;
		wr_word = {rd_gen, flags_q};
		res_rd  = '0;
		res_rd.idx = gsa_pkg::PORT_IDX_W'(slot_q);
		res_rd.gen = rd_gen;
		if (state_q == S_READ) begin
			unique case (mode_q)
				gsa_pkg::MODE_CREATE: begin
					wr_en        = 1'b1;
					wr_word      = {rd_gen, flags_q};
					res_rd.status = gsa_pkg::ST_OK;
					res_rd.flags  = flags_q;
					res_rd.active = 1'b1;
				end
				gsa_pkg::MODE_DESTROY: begin
					if (!active_q[slot_q]) begin
						res_rd.status = gsa_pkg::ST_INACTIVE;
						res_rd.flags  = rd_flags;
					end else begin
						wr_en         = 1'b1;
						wr_word       = {next_gen, gsa_pkg::FLAG_W'(0)};
						res_rd.status = gsa_pkg::ST_OK;
						res_rd.gen    = next_gen;
					end
				end
				default: begin
					if (rd_gen != hgen_q) begin
						res_rd.status = gsa_pkg::ST_GEN;
					end else begin
						res_rd.status = gsa_pkg::ST_OK;
						res_rd.flags  = rd_flags;
						res_rd.active = active_q[slot_q];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			active_q   <= '0;
			written_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser == gsa_pkg::MODE_CREATE) begin
							state_q <= S_SCAN;
						end else if (!in_range) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_SCAN: begin
					if (free_hit) begin
						state_q <= S_READ;
					end else if (chunk_q == gsa_pkg::CHUNK_W'(gsa_pkg::NUM_CHUNKS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					if (wr_en) begin
						written_q[slot_q] <= 1'b1;
					end
					if (mode_q == gsa_pkg::MODE_CREATE) begin
						active_q[slot_q] <= 1'b1;
					end else if (mode_q == gsa_pkg::MODE_DESTROY) begin
						active_q[slot_q] <= 1'b0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q  <= s_tuser;
					hgen_q  <= in_gen;
					flags_q <= in_flags;
					slot_q  <= in_idx[gsa_pkg::IDX_W-1:0];
					chunk_q <= '0;
					res_q.active <= 1'b0;
					res_q.flags  <= '0;
					res_q.gen    <= '0;
					if (s_tuser == gsa_pkg::MODE_CREATE) begin
						res_q.status <= gsa_pkg::ST_FULL;
						res_q.idx    <= '0;
					end else begin
						res_q.status <= gsa_pkg::ST_RANGE;
						res_q.idx    <= in_idx;
					end
				end
			end
			S_SCAN: begin
				slot_q  <= found_idx;
				chunk_q <= chunk_q + gsa_pkg::CHUNK_W'(1);
			end
			S_READ: begin
				res_q <= res_rd;
			end
			S_DONE: begin
				if (out_load) begin
					m_tdata_q <= {4'b0000, res_q};
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_CLK(a_create_takes_free, (state_q == S_READ && mode_q == gsa_pkg::MODE_CREATE) |-> !active_q[slot_q], "create claimed an active slot")
	`ASSERT_CLK(a_create_marks, (state_q == S_READ && mode_q == gsa_pkg::MODE_CREATE) |=> active_q[$past(slot_q)], "created slot not marked active")
	`ASSERT_CLK(a_load_from_done, $rose(m_tvalid) |-> $past(state_q == S_DONE), "result beat raised outside completion")
	`ASSERT_NEVER(a_full_only_when_full, state_q == S_DONE && mode_q == gsa_pkg::MODE_CREATE && res_q.status == gsa_pkg::ST_FULL && !(&active_q), "pool full reported with a free slot")

endmodule
